// ----- rtl/core/assert_macros.svh -----
// Assertion macros used by the controller RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define GRC_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Condition that must never be true outside reset.
`define GRC_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

// ----- rtl/core/grc_pkg.sv -----
package grc_pkg;

    // Ring and field sizes.
    localparam int RING_DEPTH = 8;
    localparam int IDX_W      = $clog2(RING_DEPTH);
    localparam int SCALE_W    = 15;
    localparam int FRAME_W    = 32;
    localparam int TIME_W     = 24;
    localparam int SEQ_W      = 32;
    localparam int STREAK_W   = 8;
    localparam int TQ_W       = 33;
    localparam int M_W        = 23;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    localparam logic [SCALE_W-1:0] SCALE_SAT = 15'h7FFF;

    // Item kinds.
    localparam logic MODE_DECLARE = 1'b0;
    localparam logic MODE_OBSERVE = 1'b1;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SCALE    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SCALE    = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BUDGET_TIME  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADROOM     = 8'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_STEP     = 8'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE       = 8'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_OVER_NEEDED  = 8'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_UNDER_NEEDED = 8'd7;

    typedef struct packed {
        logic                     mode;
        logic [FRAME_W-1:0]       frame_id;
        logic signed [TIME_W-1:0] gpu_time;
    } t_in_item;

    typedef struct packed {
        logic               scale_changed;
        logic [SCALE_W-1:0] current_scale;
        logic               sample_used;
    } t_out_item;

    typedef struct packed {
        logic               found;
        logic [SCALE_W-1:0] scale;
        logic [SEQ_W-1:0]   seq;
    } t_scan_res;

endpackage

// ----- rtl/core/grc_ring.sv -----
module grc_ring (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_declare,
    input  logic                         i_scan_start,
    input  logic [grc_pkg::FRAME_W-1:0]  i_frame,
    input  logic [grc_pkg::SCALE_W-1:0]  i_scale,
    output logic                         o_busy,
    output logic                         o_done,
    output grc_pkg::t_scan_res           o_res,
    output logic [grc_pkg::SEQ_W-1:0]    o_count
);

    logic [grc_pkg::FRAME_W-1:0] r_slot_frame [grc_pkg::RING_DEPTH];
    logic [grc_pkg::SCALE_W-1:0] r_slot_scale [grc_pkg::RING_DEPTH];
    logic [grc_pkg::SEQ_W-1:0]   r_slot_seq   [grc_pkg::RING_DEPTH];
    logic [grc_pkg::SEQ_W-1:0]   r_count;
    logic [grc_pkg::IDX_W-1:0]   r_wptr;
    logic [grc_pkg::IDX_W-1:0]   r_idx;
    logic [grc_pkg::FRAME_W-1:0] r_key;
    logic                        r_busy;
    logic                        r_done;
    grc_pkg::t_scan_res          r_res;

    logic [grc_pkg::SEQ_W-1:0] n_count;
    logic [grc_pkg::IDX_W-1:0] n_wptr;
    logic                      w_hit;
    logic                      w_last;

    // The write slot follows the count modulo the depth, and restarts when the count wraps.
    always_comb begin
        n_count = r_count + 1'b1;
        if (n_count == '0) begin
            n_wptr = '0;
        end else if (r_wptr == grc_pkg::IDX_W'(grc_pkg::RING_DEPTH - 1)) begin
            n_wptr = '0;
        end else begin
            n_wptr = r_wptr + 1'b1;
        end
    end

    // One slot is examined per cycle, in index order.
    assign w_hit  = (r_slot_seq[r_idx] != '0) && (r_slot_frame[r_idx] == r_key);
    assign w_last = (r_idx == grc_pkg::IDX_W'(grc_pkg::RING_DEPTH - 1));

    // Sequence numbers and control; a zero sequence marks an empty slot.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < grc_pkg::RING_DEPTH; i++) begin
                r_slot_seq[i] <= '0;
            end
            r_count <= '0;
            r_wptr  <= '0;
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_idx   <= '0;
        end else begin
            r_done <= r_busy && !i_scan_start && (w_hit || w_last);
            if (i_declare) begin
                r_count            <= n_count;
                r_wptr             <= n_wptr;
                r_slot_seq[n_wptr] <= n_count;
            end
            if (i_scan_start) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
            end else if (r_busy) begin
                if (w_hit || w_last) begin
                    r_busy <= 1'b0;
                end else begin
                    r_idx <= r_idx + 1'b1;
                end
            end
        end
    end

    // Slot payload and scan result.
    always_ff @(posedge i_clk) begin
        if (i_declare) begin
            r_slot_frame[n_wptr] <= i_frame;
            r_slot_scale[n_wptr] <= i_scale;
        end
        if (i_scan_start) begin
            r_key <= i_frame;
        end
        if (r_busy && (w_hit || w_last)) begin
            r_res.found <= w_hit;
            r_res.scale <= r_slot_scale[r_idx];
            r_res.seq   <= r_slot_seq[r_idx];
        end
    end

    assign o_busy  = r_busy;
    assign o_done  = r_done;
    assign o_res   = r_res;
    assign o_count = r_count;

endmodule

// ----- rtl/core/grc_arith.sv -----
module grc_arith (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [grc_pkg::SCALE_W-1:0] i_scale,
    input  logic [grc_pkg::TQ_W-1:0]    i_tq,
    input  logic [grc_pkg::M_W-1:0]     i_m,
    output logic                        o_done,
    output logic [grc_pkg::SCALE_W-1:0] o_desired
);

    // Phases: square the scale, multiply by the target, divide, root.
    localparam logic [2:0] P_IDLE = 3'd0;
    localparam logic [2:0] P_SQ   = 3'd1;
    localparam logic [2:0] P_MUL  = 3'd2;
    localparam logic [2:0] P_DIV  = 3'd3;
    localparam logic [2:0] P_ROOT = 3'd4;

    localparam int PROD_W = 63;
    localparam int SQ_W   = 2 * grc_pkg::SCALE_W;
    localparam int QUO_W  = PROD_W - 16;
    localparam int RAD_W  = QUO_W + 1;
    localparam int ROOT_W = RAD_W / 2;
    localparam int REM_W  = ROOT_W + 2;

    logic [2:0]                r_phase;
    logic [5:0]                r_cnt;
    logic [PROD_W-1:0]         r_mcand;
    logic [SQ_W-1:0]           r_mplier;
    logic [PROD_W-1:0]         r_acc;
    logic [QUO_W-1:0]          r_quo;
    logic [grc_pkg::M_W:0]     r_rem;
    logic [grc_pkg::M_W-1:0]   r_div;
    logic [RAD_W-1:0]          r_rad;
    logic [REM_W-1:0]          r_srem;
    logic [ROOT_W-1:0]         r_root;
    logic                      r_done;
    logic [grc_pkg::SCALE_W-1:0] r_desired;

    logic [PROD_W-1:0]         w_acc;
    logic [grc_pkg::M_W+1:0]   w_dtrial;
    logic                      w_dge;
    logic [REM_W+1:0]          w_strial;
    logic [REM_W+1:0]          w_sub;
    logic                      w_sge;

    // Shift-and-add step shared by both products.
    assign w_acc = r_mplier[0] ? (r_acc + r_mcand) : r_acc;

    // Restoring division step: one quotient bit per cycle.
    assign w_dtrial = {r_rem, r_quo[QUO_W-1]};
    assign w_dge    = (w_dtrial >= {1'b0, r_div});

    // Square root step: one root bit per cycle from two radicand bits.
    assign w_strial = {r_srem, r_rad[RAD_W-1:RAD_W-2]};
    assign w_sub    = {2'b00, r_root, 2'b01};
    assign w_sge    = (w_strial >= w_sub);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= P_IDLE;
            r_done  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_done <= (r_phase == P_ROOT) && (r_cnt == 6'd1);
            case (r_phase)
                P_IDLE: begin
                    if (i_start) begin
                        r_phase <= P_SQ;
                        r_cnt   <= 6'(grc_pkg::SCALE_W);
                    end
                end
                P_SQ: begin
                    if (r_cnt == 6'd1) begin
                        r_phase <= P_MUL;
                        r_cnt   <= 6'(SQ_W);
                    end else begin
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                P_MUL: begin
                    if (r_cnt == 6'd1) begin
                        r_phase <= P_DIV;
                        r_cnt   <= 6'(QUO_W);
                    end else begin
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                P_DIV: begin
                    if (r_cnt == 6'd1) begin
                        r_phase <= P_ROOT;
                        r_cnt   <= 6'(ROOT_W);
                    end else begin
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                P_ROOT: begin
                    if (r_cnt == 6'd1) begin
                        r_phase <= P_IDLE;
                    end else begin
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                default: begin
                    r_phase <= P_IDLE;
                end
            endcase
        end
    end

    // Datapath shift registers.
    always_ff @(posedge i_clk) begin
        case (r_phase)
            P_IDLE: begin
                if (i_start) begin
                    r_mcand  <= PROD_W'(i_scale);
                    r_mplier <= SQ_W'(i_scale);
                    r_acc    <= '0;
                    r_div    <= i_m;
                end
            end
            P_SQ: begin
                if (r_cnt == 6'd1) begin
                    r_mplier <= w_acc[SQ_W-1:0];
                    r_mcand  <= PROD_W'(i_tq);
                    r_acc    <= '0;
                end else begin
                    r_acc    <= w_acc;
                    r_mcand  <= {r_mcand[PROD_W-2:0], 1'b0};
                    r_mplier <= {1'b0, r_mplier[SQ_W-1:1]};
                end
            end
            P_MUL: begin
                if (r_cnt == 6'd1) begin
                    r_quo <= w_acc[PROD_W-1:16];
                    r_rem <= '0;
                end else begin
                    r_acc    <= w_acc;
                    r_mcand  <= {r_mcand[PROD_W-2:0], 1'b0};
                    r_mplier <= {1'b0, r_mplier[SQ_W-1:1]};
                end
            end
            P_DIV: begin
                if (w_dge) begin
                    r_rem <= (grc_pkg::M_W + 1)'(w_dtrial - {1'b0, r_div});
                end else begin
                    r_rem <= w_dtrial[grc_pkg::M_W:0];
                end
                r_quo <= {r_quo[QUO_W-2:0], w_dge};
                if (r_cnt == 6'd1) begin
                    r_rad  <= {1'b0, r_quo[QUO_W-2:0], w_dge};
                    r_srem <= '0;
                    r_root <= '0;
                end
            end
            P_ROOT: begin
                if (w_sge) begin
                    r_srem <= REM_W'(w_strial - w_sub);
                end else begin
                    r_srem <= w_strial[REM_W-1:0];
                end
                r_root <= {r_root[ROOT_W-2:0], w_sge};
                r_rad  <= {r_rad[RAD_W-3:0], 2'b00};
                if (r_cnt == 6'd1) begin
                    if (r_root[ROOT_W-2:grc_pkg::SCALE_W-1] != '0) begin
                        r_desired <= grc_pkg::SCALE_SAT;
                    end else begin
                        r_desired <= {r_root[grc_pkg::SCALE_W-2:0], w_sge};
                    end
                end
            end
            default: begin
                r_acc <= r_acc;
            end
        endcase
    end

    assign o_done    = r_done;
    assign o_desired = r_desired;

endmodule

// ----- rtl/core/gpu_time_resolution_controller.sv -----
// Channel   Direction  Signals                             Transfer when
// in        input      i_in_valid, o_in_ready, i_in_data   i_in_valid & o_in_ready
// out       output     o_out_valid, i_out_ready, o_out_data o_out_valid & i_out_ready
// cfg       input      i_cfg_valid, o_cfg_ready, i_cfg_*   i_cfg_valid & o_cfg_ready
//
// A declare is written to the ring. An observe scans the ring for its frame and, when
// the sample is judged out of band with a nonzero time, passes through the bit-serial
// square, product, divider and root unit.
// One item is in work at a time; the output register holds a finished result while the
// next item is accepted. Reset is synchronous and active low and restores the control and
// configuration registers. Configuration transfers are always taken.
`include "assert_macros.svh"

module gpu_time_resolution_controller (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  grc_pkg::t_in_item                i_in_data,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output grc_pkg::t_out_item               o_out_data,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [grc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [grc_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_MATH   = 3'd2;
    localparam logic [2:0] S_DECIDE = 3'd3;
    localparam logic [2:0] S_FIN    = 3'd4;

    localparam int SW = grc_pkg::SCALE_W + 3;

    logic [2:0]                      r_state;
    logic [grc_pkg::SCALE_W-1:0]     r_min;
    logic [grc_pkg::SCALE_W-1:0]     r_max;
    logic [15:0]                     r_budget;
    logic [15:0]                     r_headroom;
    logic [grc_pkg::SCALE_W-1:0]     r_step;
    logic [7:0]                      r_settle;
    logic [grc_pkg::STREAK_W-1:0]    r_over_need;
    logic [grc_pkg::STREAK_W-1:0]    r_under_need;
    logic [grc_pkg::TQ_W-1:0]        r_tq;
    logic [grc_pkg::M_W-1:0]         r_m;
    logic [grc_pkg::STREAK_W-1:0]    r_over;
    logic [grc_pkg::STREAK_W-1:0]    r_under;
    logic [grc_pkg::SCALE_W-1:0]     r_scale;
    logic [grc_pkg::SEQ_W-1:0]       r_chg_seq;
    logic                            r_chg_seen;
    logic [grc_pkg::SCALE_W-1:0]     r_desired;
    grc_pkg::t_out_item              r_res;
    grc_pkg::t_out_item              r_out;
    logic                            r_out_valid;

    logic                            w_accept;
    logic                            w_declare;
    logic                            w_observe;
    logic                            ring_busy;
    logic                            ring_done;
    grc_pkg::t_scan_res              ring_res;
    logic [grc_pkg::SEQ_W-1:0]       ring_count;
    logic                            ar_start;
    logic                            ar_done;
    logic [grc_pkg::SCALE_W-1:0]     ar_desired;
    logic [16:0]                     w_keep;
    logic                            w_settling;
    logic                            w_ignore;
    logic                            w_in_band;
    logic                            w_over;
    logic [grc_pkg::STREAK_W-1:0]    w_over_inc;
    logic [grc_pkg::STREAK_W-1:0]    w_under_inc;
    logic signed [SW-1:0]            w_des;
    logic signed [SW-1:0]            w_floor;
    logic signed [SW-1:0]            w_ceil;
    logic signed [SW-1:0]            w_v;
    logic [grc_pkg::SCALE_W-1:0]     w_next;
    logic                            w_decide;
    logic                            w_changed;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_declare   = w_accept && (i_in_data.mode == grc_pkg::MODE_DECLARE);
    assign w_observe   = w_accept && (i_in_data.mode == grc_pkg::MODE_OBSERVE);

    grc_ring u_ring (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_declare    (w_declare),
        .i_scan_start (w_observe),
        .i_frame      (i_in_data.frame_id),
        .i_scale      (r_scale),
        .o_busy       (ring_busy),
        .o_done       (ring_done),
        .o_res        (ring_res),
        .o_count      (ring_count)
    );

    grc_arith u_arith (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (ar_start),
        .i_scale   (r_scale),
        .i_tq      (r_tq),
        .i_m       (r_m),
        .o_done    (ar_done),
        .o_desired (ar_desired)
    );

    // Target in units of 2^-16 of the time step.
    assign w_keep = 17'h10000 - {1'b0, r_headroom};
    always_ff @(posedge i_clk) begin
        r_tq <= {1'b0, r_budget} * w_keep;
    end

    // Sample filter after the ring scan.
    assign w_settling = r_chg_seen &&
        ({1'b0, ring_res.seq} <= ({1'b0, r_chg_seq} + 33'(r_settle)));
    assign w_ignore   = !ring_res.found || (ring_res.scale != r_scale) || w_settling;
    assign w_in_band  = (r_m <= grc_pkg::M_W'(r_budget)) &&
        ({r_m, 16'h0000} >= 39'(r_tq));
    assign ar_start   = (r_state == S_SCAN) && ring_done && !w_ignore && !w_in_band &&
        (r_m != '0);

    // Streak update and rate-limited, clamped step.
    always_comb begin
        w_over      = (r_m > grc_pkg::M_W'(r_budget));
        w_over_inc  = (r_over == '1) ? r_over : r_over + 1'b1;
        w_under_inc = (r_under == '1) ? r_under : r_under + 1'b1;
        w_des       = SW'({3'b000, r_desired});
        w_floor     = SW'({3'b000, r_scale}) - SW'({3'b000, r_step});
        w_ceil      = SW'({3'b000, r_scale}) + SW'({3'b000, r_step});
        if (w_over) begin
            w_v      = (w_des > w_floor) ? w_des : w_floor;
            w_decide = (w_over_inc >= r_over_need);
        end else begin
            w_v      = (w_des < w_ceil) ? w_des : w_ceil;
            w_decide = (w_under_inc >= r_under_need);
        end
        if (w_v < SW'({3'b000, r_min})) begin
            w_next = r_min;
        end else if (w_v > SW'({3'b000, r_max})) begin
            w_next = r_max;
        end else begin
            w_next = w_v[grc_pkg::SCALE_W-1:0];
        end
        w_changed = w_decide && (w_next != r_scale);
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min        <= 15'd8192;
            r_max        <= 15'd16384;
            r_budget     <= 16'd4267;
            r_headroom   <= 16'd6554;
            r_step       <= 15'd1638;
            r_settle     <= 8'd4;
            r_over_need  <= 8'd2;
            r_under_need <= 8'd8;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                grc_pkg::CFG_MIN_SCALE:    r_min        <= i_cfg_data[grc_pkg::SCALE_W-1:0];
                grc_pkg::CFG_MAX_SCALE:    r_max        <= i_cfg_data[grc_pkg::SCALE_W-1:0];
                grc_pkg::CFG_BUDGET_TIME:  r_budget     <= i_cfg_data;
                grc_pkg::CFG_HEADROOM:     r_headroom   <= i_cfg_data;
                grc_pkg::CFG_MAX_STEP:     r_step       <= i_cfg_data[grc_pkg::SCALE_W-1:0];
                grc_pkg::CFG_SETTLE:       r_settle     <= i_cfg_data[7:0];
                grc_pkg::CFG_OVER_NEEDED:  r_over_need  <= i_cfg_data[7:0];
                grc_pkg::CFG_UNDER_NEEDED: r_under_need <= i_cfg_data[7:0];
                default: begin
                    r_min <= r_min;
                end
            endcase
        end
    end

    // Item sequencer and controller state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_over     <= '0;
            r_under    <= '0;
            r_scale    <= 15'd16384;
            r_chg_seq  <= '0;
            r_chg_seen <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_declare) begin
                        r_state <= S_FIN;
                    end else if (w_observe) begin
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (ring_done) begin
                        if (w_ignore) begin
                            r_state <= S_FIN;
                        end else if (w_in_band) begin
                            r_over  <= '0;
                            r_under <= '0;
                            r_state <= S_FIN;
                        end else if (r_m == '0) begin
                            r_state <= S_DECIDE;
                        end else begin
                            r_state <= S_MATH;
                        end
                    end
                end
                S_MATH: begin
                    if (ar_done) begin
                        r_state <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    if (w_changed) begin
                        r_over     <= '0;
                        r_under    <= '0;
                        r_scale    <= w_next;
                        r_chg_seq  <= ring_count;
                        r_chg_seen <= 1'b1;
                    end else if (w_over) begin
                        r_over  <= w_over_inc;
                        r_under <= '0;
                    end else begin
                        r_over  <= '0;
                        r_under <= w_under_inc;
                    end
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Item payload and pending result.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_m <= i_in_data.gpu_time[grc_pkg::TIME_W-1] ? '0 :
                i_in_data.gpu_time[grc_pkg::M_W-1:0];
            r_res.scale_changed <= 1'b0;
            r_res.current_scale <= r_scale;
            r_res.sample_used   <= 1'b0;
        end
        if ((r_state == S_SCAN) && ring_done && !w_ignore) begin
            r_res.sample_used <= 1'b1;
            r_desired         <= grc_pkg::SCALE_SAT;
        end
        if ((r_state == S_MATH) && ar_done) begin
            r_desired <= ar_desired;
        end
        if ((r_state == S_DECIDE) && w_changed) begin
            r_res.scale_changed <= 1'b1;
            r_res.current_scale <= w_next;
        end
    end

    // Output register: a finished item fills it, otherwise a transfer frees it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            if ((r_state == S_FIN) && (!r_out_valid || i_out_ready)) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_FIN) && (!r_out_valid || i_out_ready)) begin
            r_out <= r_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `GRC_ASSERT(a_changed_needs_used, i_clk, i_rst_n, o_out_valid && o_out_data.scale_changed |-> o_out_data.sample_used, "scale change reported for an unused sample")
    `GRC_ASSERT(a_scale_moves_in_decide, i_clk, i_rst_n, !$stable(r_scale) && $past(i_rst_n) |-> $past(r_state) == S_DECIDE, "scale moved outside a decision")
    `GRC_NEVER(a_no_accept_while_scanning, i_clk, i_rst_n, o_in_ready && ring_busy, "input ready while the ring scan runs")

endmodule
